// ===== rtl/core/pal_pkg.sv =====
// shared types and constants for the positional array list
package pal_pkg;

    localparam int WORD_W    = 32;
    localparam int POS_W     = 6;
    localparam int OPC_W     = 2;
    localparam int IDX_CMP_W = 9;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2
    } t_shift;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        t_shift           mode;
        logic [POS_W-1:0] k;
        t_word            word;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/pal_in_if.sv =====
// request channel of the positional array list
interface pal_in_if;
    import pal_pkg::*;

    logic               valid;
    logic               ready;
    logic [OPC_W-1:0]   opcode;
    logic [POS_W-1:0]   position;
    logic signed [WORD_W-1:0] new_value;

    modport source (output valid, output opcode, output position, output new_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input new_value,
                    output ready);
endinterface

// ===== rtl/core/pal_out_if.sv =====
// result channel of the positional array list
interface pal_out_if #(
    parameter int CNT_W = 6
);
    import pal_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [WORD_W-1:0] out_value;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, output ok, output out_value, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input out_value, input count,
                    input is_empty, input is_full, output ready);
endinterface

// ===== rtl/core/pal_cell.sv =====
// one storage cell of the list row, shifts with its neighbors
module pal_cell
    import pal_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_word      i_left,
    input  t_word      i_right,
    output t_word      o_data
);

    localparam logic [IDX_CMP_W-1:0] MY_IDX = IDX_CMP_W'(IDX);

    t_word                 r_data;
    t_word                 n_data;
    logic [IDX_CMP_W-1:0]  w_k;

    assign w_k = IDX_CMP_W'(i_ctrl.k);

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.mode)
            SH_INSERT: begin
                if (MY_IDX > w_k) begin
                    n_data = i_left;
                end else if (MY_IDX == w_k) begin
                    n_data = i_ctrl.word;
                end
            end
            SH_REMOVE: begin
                if (MY_IDX >= w_k) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/core/positional_array_list.sv =====
// top level of the positional array list
// Ordered list of up to CAPACITY signed 32-bit words kept in a row of register cells.
// Insert and remove shift all cells toward or away from the addressed position in
// parallel on the accepting edge; read and clear shift no cell. The result is held
// in an output register loaded on that edge. A new transaction is accepted every cycle
// while the result side keeps up; a stalled result holds the request side until taken.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pal_in_if.sink        i_in,
    pal_out_if.source     o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    t_word              w_cells [CAPACITY];
    t_cell_ctrl         w_ctrl;
    t_opcode            w_op;
    t_shift             w_mode;
    logic               w_acc;
    logic               w_pos_nz;
    logic               w_in_range;
    logic               w_ins_ok;
    logic [CMP_W-1:0]   w_pos_ext;
    logic [CMP_W-1:0]   w_cnt_ext;
    logic [POS_W-1:0]   w_k;
    t_word              w_rd;
    logic               w_ok;
    t_word              w_val;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_valid;
    logic               r_ok;
    t_word              r_value;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_op       = t_opcode'(i_in.opcode);
    assign w_pos_ext  = CMP_W'(i_in.position);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_pos_nz   = i_in.position != '0;
    assign w_in_range = w_pos_nz && (w_pos_ext <= w_cnt_ext);
    assign w_ins_ok   = (r_count != CNT_W'(CAPACITY)) && w_pos_nz
                        && (w_pos_ext <= w_cnt_ext + CMP_W'(1));
    assign w_k        = i_in.position - POS_W'(1);

    // word at the addressed position
    always_comb begin
        w_rd = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CMP_W'(w_k) == CMP_W'(i)) begin
                w_rd = w_cells[i];
            end
        end
    end

    always_comb begin
        w_mode  = SH_HOLD;
        w_ok    = 1'b0;
        w_val   = '0;
        n_count = r_count;
        unique case (w_op)
            OP_INSERT: begin
                if (w_ins_ok) begin
                    w_mode  = SH_INSERT;
                    w_ok    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (w_in_range) begin
                    w_mode  = SH_REMOVE;
                    w_ok    = 1'b1;
                    w_val   = w_rd;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (w_in_range) begin
                    w_ok  = 1'b1;
                    w_val = w_rd;
                end
            end
            OP_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                w_mode = SH_HOLD;
            end
        endcase
        if (!w_acc) begin
            w_mode  = SH_HOLD;
            n_count = r_count;
        end
    end

    assign w_ctrl.mode = w_mode;
    assign w_ctrl.k    = w_k;
    assign w_ctrl.word = i_in.new_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_cells[g+1];
        end
        pal_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cells[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ok    <= w_ok;
            r_value <= w_val;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.ok        = r_ok;
    assign o_out.out_value = r_value;
    assign o_out.count     = r_count;
    assign o_out.is_empty  = r_count == '0;
    assign o_out.is_full   = r_count == CNT_W'(CAPACITY);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_count))
        else $error("entry count changed without a transaction");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == OP_CLEAR) |=> (r_count == '0 && o_out.valid))
        else $error("clear did not empty the list");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ok) |-> o_out.out_value == '0)
        else $error("failed transaction returned a word");

endmodule
